/* rtl/wcrs_pkg.sv */
package wcrs_pkg;

	// Default sizes of the schedule.
	localparam int STEP_BITS_DEF     = 32;
	localparam int PROGRESS_BITS_DEF = 16;
	localparam int TABLE_DEPTH_DEF   = 256;

	// Field and register widths.
	localparam int RATE_W     = 32;
	localparam int REG_W      = 32;
	localparam int APB_ADDR_W = 4;
	localparam int COS_W      = 16;
	localparam int C17_W      = 18;

	// Shared divider sizes.
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = 7;

	// Half pi in Q2.30, used to build the cosine table.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// One half in the Q0.17 scale of the cosine weight.
	localparam logic [C17_W-1:0] C17_HALF = 18'd65536;

	// Item opcodes.
	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_RESTORE = 1'b1;

	typedef enum logic [1:0] {
		REG_BASE,
		REG_FLOOR,
		REG_RAMP,
		REG_SPAN
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLASS,
		S_MUL_W,
		S_DIV_GO,
		S_DIV_RUN,
		S_MAP,
		S_LOOK,
		S_MUL_C,
		S_SUM,
		S_DONE
	} wcrs_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} div_ctl_t;

endpackage

/* rtl/wcrs_if.sv */
interface wcrs_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] restore_value;

	modport source (output valid, output opcode, output restore_value, input ready);
	modport sink (input valid, input opcode, input restore_value, output ready);
endinterface

interface wcrs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] rate;
	logic [31:0] step_index;
	logic        config_error;

	modport source (output valid, output rate, output step_index, output config_error,
		input ready);
	modport sink (input valid, input rate, input step_index, input config_error,
		output ready);
endinterface

/* rtl/wcrs_div.sv */
module wcrs_div import wcrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctl_t             ctl,
	input  logic [DIV_DEN_W-1:0] init_rem,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quotient
);

	// Restoring division, one quotient bit per cycle. The partial remainder
	// always stays below the divisor, so it fits the divisor width.
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] dvd_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   shifted;
	logic                 ge;

	assign shifted = {rem_q, dvd_q[DIV_NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= init_rem;
			den_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(shifted - {1'b0, den_q}) : shifted[DIV_DEN_W-1:0];
			dvd_q <= {dvd_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/wcrs_cos_rom.sv */
module wcrs_cos_rom import wcrs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic [ADDR_W-1:0] addr,
	output logic [COS_W-1:0]  data
);

	// Entry j is cos(pi*j/(2*TABLE_DEPTH)) in unsigned Q0.16, from an
	// eleven-term Taylor series on a Q30 angle, rounded and saturated.
	function automatic logic [COS_W-1:0] cos_entry(input int unsigned j);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [63:0] sum;
		logic [63:0]        v;
		x   = (HALF_PI_Q30 * 64'(j) + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
		x2  = (x * x + (64'd1 << 29)) >> 30;
		t   = 64'd1 << 30;
		sum = 64'sd1 <<< 30;
		for (int k = 1; k <= 10; k++) begin
			t = (t * x2) >> 30;
			case (k)
				1:       t = t / 64'd2;
				2:       t = t / 64'd12;
				3:       t = t / 64'd30;
				4:       t = t / 64'd56;
				5:       t = t / 64'd90;
				6:       t = t / 64'd132;
				7:       t = t / 64'd182;
				8:       t = t / 64'd240;
				9:       t = t / 64'd306;
				default: t = t / 64'd380;
			endcase
			if (k % 2 == 1) begin
				sum = sum - $signed(t);
			end else begin
				sum = sum + $signed(t);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		v = ($unsigned(sum) + (64'd1 << 13)) >> 14;
		if (v > 64'd65535) begin
			v = 64'd65535;
		end
		return v[COS_W-1:0];
	endfunction

	logic [COS_W-1:0] tab [TABLE_DEPTH];
	logic [COS_W-1:0] data_q;

	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_tab
		localparam logic [COS_W-1:0] ENTRY = cos_entry(j);
		assign tab[j] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_q <= tab[addr];
	end

	assign data = data_q;

endmodule

/* rtl/warmup_cosine_rate_schedule.sv */
// Restore item: loads the step counter, gives no result.
// Advance item: the output register is loaded in the done state once the output is free;
// fast paths reach it from the class state, cosine decay via the shared one-bit-per-cycle
// divider, then map, look, multiply and sum; warmup via multiply and 64 divider quotient bits.
// One item is in work at a time; the next is taken the cycle after the result is loaded.
// Reset (arst_n low, asynchronous) clears the counter and sets the configuration registers.
module warmup_cosine_rate_schedule import wcrs_pkg::*; #(
	parameter int STEP_BITS     = STEP_BITS_DEF,
	parameter int PROGRESS_BITS = PROGRESS_BITS_DEF,
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]      pwdata,
	output logic [REG_W-1:0]      prdata,
	output logic                  pready,
	wcrs_req_if.sink              req,
	wcrs_rsp_if.source            rsp
);

	// Comparisons between the counter and the 32-bit registers are done at
	// the wider of the two widths.
	localparam int CMP_W  = (STEP_BITS > REG_W) ? STEP_BITS : REG_W;
	localparam int D2     = 2 * TABLE_DEPTH;
	localparam int HW     = $clog2(D2 + 1);
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int MAP_W  = PROGRESS_BITS + HW + 2;

	localparam logic [CMP_W-1:0] STEP_MAX_EXT = CMP_W'({STEP_BITS{1'b1}});

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete in the APB access cycle.
	// ------------------------------------------------------------------
	logic [REG_W-1:0] base_q;
	logic [REG_W-1:0] floor_q;
	logic [REG_W-1:0] ramp_q;
	logic [REG_W-1:0] span_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			floor_q <= '0;
			ramp_q  <= '0;
			span_q  <= REG_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BASE:  base_q  <= pwdata;
				REG_FLOOR: floor_q <= pwdata;
				REG_RAMP:  ramp_q  <= pwdata;
				REG_SPAN:  span_q  <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BASE:  prdata = base_q;
			REG_FLOOR: prdata = floor_q;
			REG_RAMP:  prdata = ramp_q;
			REG_SPAN:  prdata = span_q;
			default:   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and datapath state.
	// ------------------------------------------------------------------
	wcrs_state_t            state_q;
	wcrs_state_t            state_d;
	logic [STEP_BITS-1:0]   counter_q;
	logic                   out_valid_q;
	logic                   warm_q;
	logic [RATE_W-1:0]      rate_q;
	logic [2*REG_W-1:0]     prod_q;
	logic [PROGRESS_BITS-1:0] p_q;
	logic [HW-1:0]          h_q;
	logic                   upper_q;
	logic                   zero_q;
	logic [RATE_W-1:0]      out_rate_q;
	logic [REG_W-1:0]       out_step_q;
	logic                   out_err_q;

	logic                   in_acc;
	logic                   out_load;
	div_ctl_t               div_ctl;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_quo;

	// Step and register views used by the rate rules.
	logic [CMP_W-1:0]     step_ext;
	logic [CMP_W-1:0]     ramp_ext;
	logic [CMP_W-1:0]     span_ext;
	logic [REG_W-1:0]     step32;
	logic                 cfg_bad;
	logic                 step_zero;
	logic                 in_warm;
	logic                 past_end;
	logic [REG_W-1:0]     num;
	logic [REG_W-1:0]     den;

	assign step_ext  = CMP_W'(counter_q);
	assign ramp_ext  = CMP_W'(ramp_q);
	assign span_ext  = CMP_W'(span_q);
	assign step32    = REG_W'(step_ext);
	assign cfg_bad   = (span_q == '0) || (ramp_q > span_q) || (floor_q > base_q);
	assign step_zero = (counter_q == '0);
	assign in_warm   = (ramp_q != '0) && (step_ext <= ramp_ext);
	assign past_end  = (step_ext >= span_ext);
	// In the decay branch ramp < step < span, so both fit 32 bits and den > 0.
	assign num       = step32 - ramp_q;
	assign den       = span_q - ramp_q;

	// Restore value: clamp to the schedule length, then to the counter range.
	logic [REG_W-1:0] rest_min;
	logic [CMP_W-1:0] rest_ext;
	logic [CMP_W-1:0] rest_sat;

	assign rest_min = (req.restore_value < span_q) ? req.restore_value : span_q;
	assign rest_ext = CMP_W'(rest_min);
	assign rest_sat = (rest_ext > STEP_MAX_EXT) ? STEP_MAX_EXT : rest_ext;

	// ------------------------------------------------------------------
	// Shared multiplier: base*step in warmup, (base-floor)*weight in decay.
	// ------------------------------------------------------------------
	logic [REG_W-1:0]   mul_a;
	logic [REG_W-1:0]   mul_b;
	logic [COS_W-1:0]   rom_data;
	logic [COS_W-1:0]   cos_val;
	logic [C17_W-1:0]   c17;

	assign cos_val = zero_q ? '0 : rom_data;
	// Weight 0.5*(1+cos) in Q0.17: the table gives the first quarter wave and
	// its mirror gives the second.
	assign c17     = upper_q ? (C17_HALF + C17_W'(cos_val)) : (C17_HALF - C17_W'(cos_val));
	assign mul_a   = warm_q ? base_q : (base_q - floor_q);
	assign mul_b   = warm_q ? step32 : REG_W'(c17);

	// ------------------------------------------------------------------
	// Progress to half-wave table position, rounded half up and clamped.
	// ------------------------------------------------------------------
	logic [MAP_W-1:0] map_sum;
	logic [MAP_W-1:0] h_raw;
	logic [HW-1:0]    h_next;

	assign map_sum = MAP_W'(p_q) * MAP_W'(D2) + (MAP_W'(1) << (PROGRESS_BITS - 1));
	assign h_raw   = map_sum >> PROGRESS_BITS;
	assign h_next  = (h_raw > MAP_W'(D2)) ? HW'(D2) : HW'(h_raw);

	// Table address: the position itself in the first quarter, its mirror in
	// the second. The exact quarter point reads as zero.
	logic              look_upper;
	logic              look_zero;
	logic [ADDR_W-1:0] rom_addr;

	assign look_upper = (h_q <= HW'(TABLE_DEPTH));
	assign look_zero  = (h_q == HW'(TABLE_DEPTH));
	always_comb begin
		if (look_zero) begin
			rom_addr = '0;
		end else if (look_upper) begin
			rom_addr = ADDR_W'(h_q);
		end else begin
			rom_addr = ADDR_W'(HW'(D2) - h_q);
		end
	end

	wcrs_cos_rom #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// The divider either forms base*step/ramp (64 quotient bits from the
	// registered product) or the progress fraction num/den, which needs only
	// PROGRESS_BITS quotient bits because num < den.
	wcrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.init_rem (warm_q ? '0 : num),
		.dividend (warm_q ? prod_q : '0),
		.divisor  (warm_q ? ramp_q : den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && req.opcode == OP_ADVANCE) begin
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				if (cfg_bad || step_zero) begin
					state_d = S_DONE;
				end else if (in_warm) begin
					state_d = S_MUL_W;
				end else if (past_end) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV_GO;
				end
			end
			S_MUL_W:   state_d = S_DIV_GO;
			S_DIV_GO:  state_d = S_DIV_RUN;
			S_DIV_RUN: begin
				if (div_done) begin
					state_d = warm_q ? S_DONE : S_MAP;
				end
			end
			S_MAP:     state_d = S_LOOK;
			S_LOOK:    state_d = S_MUL_C;
			S_MUL_C:   state_d = S_SUM;
			S_SUM:     state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs.
	// ------------------------------------------------------------------
	always_comb begin
		req.ready     = (state_q == S_IDLE);
		in_acc        = req.valid && (state_q == S_IDLE);
		out_load      = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
		div_ctl.start = (state_q == S_DIV_GO);
		div_ctl.iters = warm_q ? DIV_CNT_W'(DIV_NUM_W) : DIV_CNT_W'(PROGRESS_BITS);
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (req.opcode == OP_RESTORE) begin
					counter_q <= STEP_BITS'(rest_sat);
				end else if (CMP_W'(counter_q) != STEP_MAX_EXT) begin
					// The counter holds at the top of its range.
					counter_q <= counter_q + STEP_BITS'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q) inside
			S_CLASS: begin
				warm_q <= in_warm;
				// A bad configuration or step 0 gives rate 0; past the end gives the floor.
				rate_q <= (cfg_bad || step_zero) ? '0 : floor_q;
			end
			S_MUL_W, S_MUL_C: begin
				prod_q <= mul_a * mul_b;
			end
			S_DIV_RUN: begin
				if (div_done) begin
					rate_q <= RATE_W'(div_quo);
					p_q    <= PROGRESS_BITS'(div_quo);
				end
			end
			S_MAP: begin
				h_q <= h_next;
			end
			S_LOOK: begin
				upper_q <= look_upper;
				zero_q  <= look_zero;
			end
			S_SUM: begin
				rate_q <= floor_q + prod_q[RATE_W+16:17];
			end
			default: ;
		endcase
		if (out_load) begin
			out_rate_q <= rate_q;
			out_step_q <= step32;
			out_err_q  <= cfg_bad;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.rate         = out_rate_q;
	assign rsp.step_index   = out_step_q;
	assign rsp.config_error = out_err_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_div_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_RUN)
		else $error("divider finished outside its wait state");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item did not reach the output register");

	a_restore_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.opcode == OP_RESTORE) |=> state_q == S_IDLE)
		else $error("restore item started a rate computation");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |=> state_q == S_DIV_RUN && !div_done)
		else $error("divider start not followed by its wait state");

endmodule
